@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the page replacement RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/fpr_pkg.sv @@
// Constants and types shared by the FIFO page replacement block.
`default_nettype none
package fpr_pkg;

  localparam int PAGES    = 64;
  localparam int FRAMES   = 8;
  localparam int PAGE_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int FRAME_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FCOUNT_W = $clog2(FRAMES + 1);
  localparam int CFG_W    = 4;
  localparam int DISK_W   = 32;

  localparam logic [CFG_W-1:0] FRAME_COUNT_RST = CFG_W'(FRAMES);

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              dirty;
  } req_t;

  typedef struct packed {
    logic               we;
    logic [PAGE_W-1:0]  addr;
    logic [FRAME_W-1:0] data;
  } frame_wr_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               evicted;
    logic [PAGE_W-1:0]  victim;
    logic               write_back;
    logic [DISK_W-1:0]  disk_count;
  } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/fpr_req_if.sv @@
// Access request channel: valid/ready handshake with page and dirty flag.
`default_nettype none
interface fpr_req_if;
  logic       valid;
  logic       ready;
  logic [5:0] page_number;
  logic       mark_dirty;

  modport source (output valid, output page_number, output mark_dirty, input ready);
  modport sink (input valid, input page_number, input mark_dirty, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fpr_rsp_if.sv @@
// Access result channel: valid/ready handshake with the translation result.
`default_nettype none
interface fpr_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [2:0]  frame_number;
  logic        evicted;
  logic [5:0]  victim_page;
  logic        write_back;
  logic [31:0] disk_access_count;

  modport source (output valid, output hit, output frame_number, output evicted,
                  output victim_page, output write_back, output disk_access_count,
                  input ready);
  modport sink (input valid, input hit, input frame_number, input evicted,
                input victim_page, input write_back, input disk_access_count,
                output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fifo_page_replacement.sv @@
// Top level of the FIFO page replacement block.
// Each request transaction is one access to a virtual page. The block answers
// with exactly one result transaction: whether the page was resident, the frame
// that now holds it, whether an older page was evicted (in first-in-first-out
// load order) to make room, whether that victim must be written back, and the
// running, saturating count of disk accesses. The frame_count register limits
// how many frames are used; write it only while no transaction is in flight.
// An access is captured in an input register on the cycle it is accepted, and
// is resolved against the page table and written into the result register when
// that register is free or being drained. While the sink takes every result, a
// new access can be accepted every cycle: one access per clock.
// The per-page frame numbers live in a 64-entry RAM read while the request is
// captured; a write from the access being resolved in the same cycle is
// forwarded around it. No clearing pass is needed after reset: the valid and
// dirty flags reset at once and the block is ready on the first cycle.
`default_nettype none
module fifo_page_replacement (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [fpr_pkg::CFG_W-1:0] cfg_wdata,
  fpr_req_if.sink                        req,
  fpr_rsp_if.source                      rsp
);
  import fpr_pkg::*;

  // Configuration register.
  logic [CFG_W-1:0] frame_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RST;
    end else if (cfg_we) begin
      frame_count <= cfg_wdata;
    end
  end

  // Input register stage. The held access is resolved when the result register
  // is free or is being drained in the same cycle.
  logic               req_held;
  req_t               req_q;
  logic               rsp_valid;
  result_t            result_q;
  logic               fire;
  logic               accept;
  result_t            result;
  frame_wr_t          frame_wr;
  logic [FRAME_W-1:0] ram_rdata;
  logic               fwd_sel;
  logic [FRAME_W-1:0] fwd_data;
  logic [FRAME_W-1:0] page_frame_rd;

  assign fire      = req_held && (!rsp_valid || rsp.ready);
  assign req.ready = !req_held || fire;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_held <= 1'b0;
    end else if (accept) begin
      req_held <= 1'b1;
    end else if (fire) begin
      req_held <= 1'b0;
    end
  end

  // Page numbers beyond the table wrap; with a power-of-two table this is the
  // low bits of the field.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q.page  <= PAGE_W'(req.page_number);
      req_q.dirty <= req.mark_dirty;
      // The access being resolved right now may be loading the same page.
      fwd_sel     <= frame_wr.we && (frame_wr.addr == PAGE_W'(req.page_number));
      fwd_data    <= frame_wr.data;
    end
  end

  fpr_frame_ram #(
    .DEPTH (PAGES),
    .WIDTH (FRAME_W)
  ) u_frame_ram (
    .clk   (clk),
    .we    (frame_wr.we),
    .waddr (frame_wr.addr),
    .wdata (frame_wr.data),
    .re    (accept),
    .raddr (PAGE_W'(req.page_number)),
    .rdata (ram_rdata)
  );

  assign page_frame_rd = fwd_sel ? fwd_data : ram_rdata;

  fpr_replace u_replace (
    .clk           (clk),
    .rst           (rst),
    .frame_count   (frame_count),
    .fire          (fire),
    .req           (req_q),
    .page_frame_rd (page_frame_rd),
    .result        (result),
    .frame_wr      (frame_wr)
  );

  // Result register: holds a finished result until the sink takes it, while
  // the input register already captures the next access.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_q <= result;
    end
  end

  assign rsp.valid             = rsp_valid;
  assign rsp.hit               = result_q.hit;
  assign rsp.frame_number      = 3'(result_q.frame);
  assign rsp.evicted           = result_q.evicted;
  assign rsp.victim_page       = 6'(result_q.victim);
  assign rsp.write_back        = result_q.write_back;
  assign rsp.disk_access_count = result_q.disk_count;

endmodule
`default_nettype wire

@@ hw/rtl/fpr_frame_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fpr_frame_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 3,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/fpr_replace.sv @@
// Page table flags, FIFO victim pointer, frame owners and disk counter.
`default_nettype none
`include "assert_macros.svh"
module fpr_replace (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [fpr_pkg::CFG_W-1:0]    frame_count,
  input  wire logic                         fire,
  input  wire fpr_pkg::req_t                req,
  input  wire logic [fpr_pkg::FRAME_W-1:0]  page_frame_rd,
  output fpr_pkg::result_t                  result,
  output fpr_pkg::frame_wr_t                frame_wr
);
  import fpr_pkg::*;

  logic [PAGES-1:0]    page_valid;
  logic [PAGES-1:0]    page_dirty;
  logic [PAGE_W-1:0]   frame_owner [FRAMES];
  logic [FCOUNT_W-1:0] frames_used;
  logic [FRAME_W-1:0]  oldest;
  logic [DISK_W-1:0]   disk_counter;

  logic [FCOUNT_W-1:0] eff_n;
  logic                hit;
  logic                has_free;
  logic                evict;
  logic [FRAME_W-1:0]  oldest_w;
  logic [FCOUNT_W-1:0] oldest_inc;
  logic [FRAME_W-1:0]  oldest_next;
  logic [PAGE_W-1:0]   victim;
  logic                wb;
  logic [FRAME_W-1:0]  frame;
  logic [DISK_W:0]     disk_sum;
  logic [DISK_W-1:0]   disk_next;

  // A zero count acts as one frame; counts above the frame store clamp to it.
  always_comb begin
    if (frame_count == '0) begin
      eff_n = FCOUNT_W'(1);
    end else if (int'(frame_count) > FRAMES) begin
      eff_n = FCOUNT_W'(FRAMES);
    end else begin
      eff_n = FCOUNT_W'(frame_count);
    end
  end

  always_comb begin
    hit         = page_valid[req.page];
    has_free    = frames_used < eff_n;
    evict       = !hit && !has_free;
    oldest_w    = (FCOUNT_W'(oldest) >= eff_n) ? '0 : oldest;
    oldest_inc  = FCOUNT_W'(oldest_w) + FCOUNT_W'(1);
    oldest_next = (oldest_inc >= eff_n) ? '0 : FRAME_W'(oldest_inc);
    victim      = frame_owner[oldest_w];
    wb          = evict && page_dirty[victim];

    if (hit) begin
      frame = page_frame_rd;
    end else if (has_free) begin
      frame = FRAME_W'(frames_used);
    end else begin
      frame = oldest_w;
    end

    // One access always counts; a dirty write-back counts once more.
    disk_sum  = {1'b0, disk_counter} + (DISK_W+1)'({wb, !wb});
    disk_next = disk_sum[DISK_W] ? '1 : disk_sum[DISK_W-1:0];

    result.hit        = hit;
    result.frame      = frame;
    result.evicted    = evict;
    result.victim     = evict ? victim : '0;
    result.write_back = wb;
    result.disk_count = disk_next;

    frame_wr.we   = fire && !hit;
    frame_wr.addr = req.page;
    frame_wr.data = frame;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid   <= '0;
      page_dirty   <= '0;
      frames_used  <= '0;
      oldest       <= '0;
      disk_counter <= '0;
    end else if (fire) begin
      disk_counter <= disk_next;
      if (!hit && has_free) begin
        frames_used <= frames_used + FCOUNT_W'(1);
      end
      if (evict) begin
        page_valid[victim] <= 1'b0;
        page_dirty[victim] <= 1'b0;
        oldest             <= oldest_next;
      end
      // The victim is resident and the new page is not, so they never collide.
      if (!hit) begin
        page_valid[req.page] <= 1'b1;
      end
      if (req.dirty) begin
        page_dirty[req.page] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !hit) begin
      frame_owner[frame] <= req.page;
    end
  end

  `ASSERT_RST(a_victim_resident, clk, rst, !(fire && evict) || page_valid[victim], "victim page is not resident")
  `ASSERT_RST(a_frames_bounded, clk, rst, int'(frames_used) <= FRAMES, "frames in use exceed the frame store")
  `ASSERT_NEXT(a_disk_grows, clk, rst, fire && (disk_counter != '1), disk_counter > $past(disk_counter), "disk counter failed to advance")

endmodule
`default_nettype wire
